[rtl/core/seismic_record_class_filter_core_defines.svh]
// Assertion macros for the seismic record class filter checker.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef SEISMIC_RECORD_CLASS_FILTER_CORE_DEFINES_SVH
`define SEISMIC_RECORD_CLASS_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SRCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SRCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/srcf_pkg.sv]
// Shared types, constants and match functions of the record class filter.
// No dependencies; used by every module of the block.
package srcf_pkg;

	localparam int SEL_PER_LIST = 16;
	localparam int NUM_LISTS    = 3;
	localparam int MEM_DEPTH    = NUM_LISTS * SEL_PER_LIST;
	localparam int ADDR_W       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int LEN_W        = 5;
	localparam int NUM_CLASSES  = 6;

	localparam logic [7:0]  CHAR_WILD = 8'h3F;
	localparam logic [7:0]  CHAR_LC_A = 8'h61;
	localparam logic [7:0]  CHAR_LC_Z = 8'h7A;
	localparam logic [7:0]  CASE_DIFF = 8'h20;
	localparam logic [15:0] BT_DET_LO = 16'd200;
	localparam logic [15:0] BT_CAL_LO = 16'd300;
	localparam logic [15:0] BT_CAL_HI = 16'd400;
	localparam logic [15:0] BT_TIM_LO = 16'd500;
	localparam logic [15:0] BT_TIM_HI = 16'd600;
	localparam logic [15:0] BT_1000   = 16'd1000;
	localparam logic [15:0] BT_2000   = 16'd2000;

	typedef enum logic [1:0] {
		ACT_LOAD      = 2'd0,
		ACT_BLOCKETTE = 2'd1,
		ACT_END       = 2'd2
	} action_e;

	typedef enum logic [2:0] {
		CLS_DATA   = 3'd0,
		CLS_DETECT = 3'd1,
		CLS_CALIB  = 3'd2,
		CLS_TIMING = 3'd3,
		CLS_LOG    = 3'd4,
		CLS_BLOCK  = 3'd5
	} rec_class_e;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  list_type;
		logic [3:0]  entry_index;
		logic [39:0] entry_pattern;
		logic [15:0] blockette_type;
		logic        header_ok;
		logic        rate_is_zero;
		logic        count_is_zero;
		logic [39:0] record_id;
	} in_item_t;

	typedef struct packed {
		logic       keep;
		logic [2:0] record_class;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic blk;
		logic capture;
		logic step;
		logic emit;
		logic cfg_wr;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_done;
	} dp_status_t;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			r = c - CASE_DIFF;
		end
		return r;
	endfunction

	// Five independent character compares; '?' on either side matches
	function automatic logic pattern_hits(input logic [39:0] id, input logic [39:0] pat);
		logic       hit;
		logic [7:0] a;
		logic [7:0] b;
		hit = 1'b1;
		for (int k = 0; k < 5; k++) begin
			a = id[8*k +: 8];
			b = pat[8*k +: 8];
			if (a != CHAR_WILD && b != CHAR_WILD && upcase(a) != upcase(b)) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

[rtl/core/seismic_record_class_filter_core.sv]
// Top level of the seismic record class filter.
// Depends on srcf_pkg, srcf_ctrl and srcf_dp.
//
// Usage:
//   Items enter on item when start is high and busy is low. A selector load
//   or a blockette item is taken at once; busy stays low, so these items may
//   arrive in every cycle.
//   An end-of-record item raises busy while the stored selectors of the
//   record's class are read one per cycle from the selector memory and
//   compared with record_id; done rises once the last entry has been
//   compared. When no list check is needed (or the list is empty), no
//   entry is compared. The memory read port is registered, and each entry
//   is compared from its output.
//   result carries keep and record_class in the cycle in which done is
//   high and holds them until the next result; the receiver cannot stall,
//   and a new item may be taken in that same cycle.
//   save_flags is written on cfg_data when cfg_valid and cfg_ready are both
//   high; cfg_ready is low while busy.
//   Reset clears the save flags, the list lengths and the record state;
//   selector entries hold no reset value and must be loaded before use.
module seismic_record_class_filter_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  srcf_pkg::in_item_t    item,
	output logic                  busy,
	output logic                  done,
	output srcf_pkg::out_item_t   result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [5:0]            cfg_data
);

	srcf_pkg::dp_cmd_t    cmd;
	srcf_pkg::dp_status_t status;

	srcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (item.action),
		.cfg_valid (cfg_valid),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done)
	);

	srcf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.cfg_data (cfg_data),
		.status   (status),
		.result   (result)
	);

endmodule

[rtl/core/srcf_ctrl.sv]
// Controller of the record class filter: item decode and selector walk sequencing.
// Depends on srcf_pkg.
module srcf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             action,
	input  logic                   cfg_valid,
	input  srcf_pkg::dp_status_t   status,
	output srcf_pkg::dp_cmd_t      cmd,
	output logic                   busy,
	output logic                   cfg_ready,
	output logic                   done
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_e;

	state_e state_q;
	logic   done_q;
	logic   accept;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done      = done_q;
	assign accept    = start && (state_q == ST_IDLE);

	// Command decode
	always_comb begin
		cmd         = '0;
		cmd.load    = accept && (action == srcf_pkg::ACT_LOAD);
		cmd.blk     = accept && (action == srcf_pkg::ACT_BLOCKETTE);
		cmd.capture = accept && (action == srcf_pkg::ACT_END);
		cmd.step    = (state_q == ST_WALK);
		cmd.emit    = (state_q == ST_WALK) && status.walk_done;
		cmd.cfg_wr  = cfg_valid && (state_q == ST_IDLE);
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (status.walk_done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/srcf_dp.sv]
// Datapath of the record class filter: record state, selector memory, matcher.
// Depends on srcf_pkg.
module srcf_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srcf_pkg::dp_cmd_t      cmd,
	input  srcf_pkg::in_item_t     item,
	input  logic [5:0]             cfg_data,
	output srcf_pkg::dp_status_t   status,
	output srcf_pkg::out_item_t    result
);

	localparam int ADDR_W = srcf_pkg::ADDR_W;
	localparam int LEN_W  = srcf_pkg::LEN_W;

	logic [srcf_pkg::NUM_CLASSES-1:0] save_flags_q;
	logic [39:0]       sel_mem [srcf_pkg::MEM_DEPTH];
	logic [LEN_W-1:0]  len_q [srcf_pkg::NUM_LISTS];

	srcf_pkg::rec_class_e class_q;
	logic                 fixed_q;
	logic                 seen1000_q;
	logic                 seen2000_q;

	// End-of-record evaluation registers
	logic [2:0]        eval_cls_q;
	logic              pre_keep_q;
	logic              need_q;
	logic [LEN_W-1:0]  walk_len_q;
	logic [ADDR_W-1:0] base_q;
	logic [39:0]       id_q;
	logic [LEN_W-1:0]  issue_cnt_q;
	logic              hit_q;
	logic              pend_s1;
	logic [39:0]       rd_data_s1;
	srcf_pkg::out_item_t result_q;

	logic              ld_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              issue;
	srcf_pkg::rec_class_e cls_end;
	logic              pre_keep;
	logic              need;
	logic [LEN_W-1:0]  sel_len;
	logic [15:0]       bt;

	// Selector load decode
	assign ld_ok   = (32'(item.list_type) < srcf_pkg::NUM_LISTS)
		&& (32'(item.entry_index) < srcf_pkg::SEL_PER_LIST);
	assign wr_addr = ADDR_W'(32'(item.list_type) * srcf_pkg::SEL_PER_LIST
		+ 32'(item.entry_index));

	// Selector memory: one write port, one registered read port
	assign issue   = cmd.step && (issue_cnt_q < walk_len_q);
	assign rd_addr = base_q + ADDR_W'(issue_cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok) begin
			sel_mem[wr_addr] <= item.entry_pattern;
		end
		rd_data_s1 <= sel_mem[rd_addr];
	end

	// Final class and keep decision before the selector check
	always_comb begin
		cls_end = class_q;
		if (class_q == srcf_pkg::CLS_DATA && item.rate_is_zero && !item.count_is_zero) begin
			cls_end = srcf_pkg::CLS_LOG;
		end else if (class_q == srcf_pkg::CLS_DATA && item.rate_is_zero
			&& item.count_is_zero && seen2000_q) begin
			cls_end = srcf_pkg::CLS_BLOCK;
		end
		pre_keep = item.header_ok && save_flags_q[cls_end]
			&& !(cls_end == srcf_pkg::CLS_DATA
			&& (!seen1000_q || (item.rate_is_zero && item.count_is_zero)));
		unique case (cls_end)
			srcf_pkg::CLS_DATA:   sel_len = len_q[0];
			srcf_pkg::CLS_DETECT: sel_len = len_q[1];
			srcf_pkg::CLS_CALIB:  sel_len = len_q[2];
			default:              sel_len = '0;
		endcase
		need = pre_keep && (cls_end == srcf_pkg::CLS_DATA
			|| cls_end == srcf_pkg::CLS_DETECT || cls_end == srcf_pkg::CLS_CALIB);
	end

	assign bt = item.blockette_type;
	assign status.walk_done = (issue_cnt_q == walk_len_q) && !pend_s1;
	assign result = result_q;

	// Configuration, list lengths and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			save_flags_q <= '0;
			for (int i = 0; i < srcf_pkg::NUM_LISTS; i++) begin
				len_q[i] <= '0;
			end
			class_q    <= srcf_pkg::CLS_DATA;
			fixed_q    <= 1'b0;
			seen1000_q <= 1'b0;
			seen2000_q <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				save_flags_q <= cfg_data;
			end
			if (cmd.load && ld_ok) begin
				len_q[item.list_type] <= LEN_W'({1'b0, item.entry_index} + 5'd1);
			end
			if (cmd.blk && !fixed_q) begin
				priority if (bt >= srcf_pkg::BT_DET_LO && bt < srcf_pkg::BT_CAL_LO) begin
					class_q <= srcf_pkg::CLS_DETECT;
					fixed_q <= 1'b1;
				end else if (bt >= srcf_pkg::BT_CAL_LO && bt <= srcf_pkg::BT_CAL_HI) begin
					class_q <= srcf_pkg::CLS_CALIB;
					fixed_q <= 1'b1;
				end else if (bt >= srcf_pkg::BT_TIM_LO && bt < srcf_pkg::BT_TIM_HI) begin
					class_q <= srcf_pkg::CLS_TIMING;
					fixed_q <= 1'b1;
				end else if (bt == srcf_pkg::BT_1000) begin
					seen1000_q <= 1'b1;
				end else if (bt == srcf_pkg::BT_2000) begin
					seen2000_q <= 1'b1;
				end
			end
			if (cmd.capture) begin
				class_q    <= srcf_pkg::CLS_DATA;
				fixed_q    <= 1'b0;
				seen1000_q <= 1'b0;
				seen2000_q <= 1'b0;
			end
		end
	end

	// Selector walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_len_q  <= '0;
			issue_cnt_q <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (cmd.capture) begin
				walk_len_q  <= need ? sel_len : '0;
				issue_cnt_q <= '0;
				pend_s1     <= 1'b0;
				hit_q       <= 1'b0;
			end else if (cmd.step) begin
				pend_s1 <= issue;
				if (issue) begin
					issue_cnt_q <= issue_cnt_q + LEN_W'(1);
				end
				if (pend_s1 && srcf_pkg::pattern_hits(id_q, rd_data_s1)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Evaluation payload and result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			eval_cls_q <= cls_end;
			pre_keep_q <= pre_keep;
			need_q     <= need;
			id_q       <= item.record_id;
			base_q     <= ADDR_W'(32'(cls_end) * srcf_pkg::SEL_PER_LIST);
		end
		if (cmd.emit) begin
			result_q.keep         <= pre_keep_q && (!need_q || hit_q);
			result_q.record_class <= eval_cls_q;
		end
	end

endmodule

[rtl/core/srcf_checker.sv]
// Port-level checker for the record class filter, bound to the top level.
// Depends on srcf_pkg and seismic_record_class_filter_core_defines.svh.
`include "seismic_record_class_filter_core_defines.svh"

module srcf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input srcf_pkg::in_item_t  item,
	input logic                busy,
	input logic                done
);

	logic end_xfer;

	assign end_xfer = start && !busy && (item.action == srcf_pkg::ACT_END);

	// An end-of-record transfer always starts a selector walk
	`SRCF_ASSERT_NEXT(a_end_sets_busy, end_xfer, busy, "end item did not raise busy")

	// A result only shows once the walk is over
	`SRCF_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

	// Finishing a walk always delivers its result
	`SRCF_ASSERT_NOW(a_fall_done, $fell(busy), done, "walk ended without a result")

	// Two results never come in adjacent cycles
	`SRCF_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

bind seismic_record_class_filter_core srcf_checker u_srcf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.item   (item),
	.busy   (busy),
	.done   (done)
);

[tb/tb_top.sv]
// Self-checking testbench for seismic_record_class_filter_core.
// Depends on srcf_pkg and the core RTL. It predicts each end-of-record verdict from
// the accepted items and checks it against the result port, in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srcf_pkg::*;

	localparam logic [1:0] LIST_DATA   = 2'd0;
	localparam logic [1:0] LIST_DETECT = 2'd1;
	localparam logic [1:0] LIST_CALIB  = 2'd2;
	localparam logic [1:0] LIST_NONE   = 2'd3;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 138;
	// letters in both cases plus the non-letters around the case ranges
	localparam logic [79:0] CHAR_SET = "AaBbZz@[`{";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	in_item_t    item;
	logic        busy;
	logic        done;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	// Predictor state
	logic [39:0] sel_bank [NUM_LISTS][SEL_PER_LIST];
	int          sel_len [NUM_LISTS] = '{0, 0, 0};
	int          bank_filled [NUM_LISTS] = '{0, 0, 0};
	rec_class_e  rec_cls = CLS_DATA;
	logic        cls_fixed = 1'b0;
	logic        got_1000 = 1'b0;
	logic        got_2000 = 1'b0;
	logic [5:0]  save_mask = '0;

	out_item_t   verdicts_due [$];
	int          bad_checks = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          quiet_cycles = 0;

	seismic_record_class_filter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Character compare: '?' on either side matches, letters compare caseless
	function automatic logic chars_agree(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] fa;
		logic [7:0] fb;
		if (a == CHAR_WILD || b == CHAR_WILD) begin
			return 1'b1;
		end
		fa = (a >= CHAR_LC_A && a <= CHAR_LC_Z) ? (a & 8'hDF) : a;
		fb = (b >= CHAR_LC_A && b <= CHAR_LC_Z) ? (b & 8'hDF) : b;
		return fa == fb;
	endfunction

	function automatic logic id_selected(input int lst, input logic [39:0] id);
		logic hit;
		for (int i = 0; i < sel_len[lst]; i++) begin
			hit = 1'b1;
			for (int k = 0; k < 5; k++) begin
				if (!chars_agree(id[8*k +: 8], sel_bank[lst][i][8*k +: 8])) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Advance the predicted state by one accepted item
	function automatic void apply_item(input in_item_t it);
		rec_class_e cls;
		logic       keep;
		int         lst;
		logic [15:0] bt;
		lst = int'(it.list_type);
		bt = it.blockette_type;
		case (action_e'(it.action))
			ACT_LOAD: begin
				if (lst < NUM_LISTS) begin
					sel_bank[lst][it.entry_index] = it.entry_pattern;
					sel_len[lst] = int'(it.entry_index) + 1;
					if (int'(it.entry_index) == bank_filled[lst]) begin
						bank_filled[lst]++;
					end
				end
			end
			ACT_BLOCKETTE: begin
				if (!cls_fixed) begin
					if (bt >= BT_DET_LO && bt < BT_CAL_LO) begin
						rec_cls = CLS_DETECT;
						cls_fixed = 1'b1;
					end else if (bt >= BT_CAL_LO && bt <= BT_CAL_HI) begin
						rec_cls = CLS_CALIB;
						cls_fixed = 1'b1;
					end else if (bt >= BT_TIM_LO && bt < BT_TIM_HI) begin
						rec_cls = CLS_TIMING;
						cls_fixed = 1'b1;
					end else if (bt == BT_1000) begin
						got_1000 = 1'b1;
					end else if (bt == BT_2000) begin
						got_2000 = 1'b1;
					end
				end
			end
			ACT_END: begin
				cls = rec_cls;
				keep = it.header_ok;
				if (cls == CLS_DATA && it.rate_is_zero && !it.count_is_zero) begin
					cls = CLS_LOG;
				end
				if (cls == CLS_DATA && it.rate_is_zero && it.count_is_zero && got_2000) begin
					cls = CLS_BLOCK;
				end
				if (cls == CLS_DATA && !got_1000) begin
					keep = 1'b0;
				end
				if (cls == CLS_DATA && it.rate_is_zero && it.count_is_zero) begin
					keep = 1'b0;
				end
				if (keep && !save_mask[cls]) begin
					keep = 1'b0;
				end
				if (keep && cls <= CLS_CALIB && !id_selected(int'(cls), it.record_id)) begin
					keep = 1'b0;
				end
				verdicts_due.push_back('{keep: keep, record_class: cls});
				rec_cls = CLS_DATA;
				cls_fixed = 1'b0;
				got_1000 = 1'b0;
				got_2000 = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [39:0] rand40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	// Five chars from a small set so that selectors hit often
	function automatic logic [39:0] rand_text(input int wild_pct);
		logic [39:0] s;
		for (int k = 0; k < 5; k++) begin
			if ($urandom_range(0, 99) < wild_pct) begin
				s[8*k +: 8] = CHAR_WILD;
			end else if ($urandom_range(0, 7) == 0) begin
				s[8*k +: 8] = 8'($urandom);
			end else begin
				s[8*k +: 8] = CHAR_SET[8*$urandom_range(0, 9) +: 8];
			end
		end
		return s;
	endfunction

	// Every field but the action random; callers set what matters for the action
	function automatic in_item_t base_item();
		in_item_t it;
		it.action         = ACT_UNUSED;
		it.list_type      = 2'($urandom);
		it.entry_index    = 4'($urandom);
		it.entry_pattern  = rand40();
		it.blockette_type = 16'($urandom);
		it.header_ok      = 1'($urandom);
		it.rate_is_zero   = 1'($urandom);
		it.count_is_zero  = 1'($urandom);
		it.record_id      = rand40();
		return it;
	endfunction

	function automatic logic [15:0] pick_type();
		case ($urandom_range(0, 15))
			0, 1, 2, 3: return BT_1000;
			4: return BT_2000;
			5: return BT_DET_LO - 16'd1;
			6: return BT_DET_LO;
			7: return BT_CAL_LO - 16'd1;
			8: return BT_CAL_LO;
			9: return BT_CAL_HI;
			10: return BT_CAL_HI + 16'd1;
			11: return BT_TIM_LO;
			12: return BT_TIM_HI - 16'd1;
			13: return BT_TIM_HI;
			default: return 16'($urandom);
		endcase
	endfunction

	// One input transfer, with random gaps between bursts
	task automatic transfer_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_item(it);
		items_sent++;
	endtask

	task automatic send_load(input logic [1:0] lst, input logic [3:0] idx,
			input logic [39:0] pat);
		in_item_t it;
		it = base_item();
		it.action = ACT_LOAD;
		it.list_type = lst;
		it.entry_index = idx;
		it.entry_pattern = pat;
		transfer_item(it);
	endtask

	task automatic send_blockette(input logic [15:0] bt);
		in_item_t it;
		it = base_item();
		it.action = ACT_BLOCKETTE;
		it.blockette_type = bt;
		transfer_item(it);
	endtask

	task automatic send_end(input logic hdr, input logic rate0, input logic count0,
			input logic [39:0] id);
		in_item_t it;
		it = base_item();
		it.action = ACT_END;
		it.header_ok = hdr;
		it.rate_is_zero = rate0;
		it.count_is_zero = count0;
		it.record_id = id;
		transfer_item(it);
	endtask

	// Load only slots at or below the first never-written one
	task automatic send_rand_load();
		int lst;
		int top;
		lst = ($urandom_range(0, 7) == 0) ? int'(LIST_NONE) : $urandom_range(0, 2);
		if (lst == int'(LIST_NONE)) begin
			top = SEL_PER_LIST - 1;
		end else if (bank_filled[lst] < SEL_PER_LIST && $urandom_range(0, 1) == 1) begin
			top = bank_filled[lst];
		end else begin
			top = (bank_filled[lst] < SEL_PER_LIST) ? bank_filled[lst] : SEL_PER_LIST - 1;
		end
		if (lst != int'(LIST_NONE) && top == bank_filled[lst]) begin
			send_load(2'(lst), 4'(top), rand_text(30));
		end else begin
			send_load(2'(lst), 4'($urandom_range(0, top)), rand_text(30));
		end
	endtask

	// Pause the sender until every verdict has arrived and the walk is over
	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_save_flags(input logic [5:0] flags);
		wait_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= flags;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		save_mask = flags;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A record: a few blockettes, maybe a selector load inside, then the end item
	task automatic random_record();
		logic data_style;
		int   n;
		data_style = ($urandom_range(0, 2) == 0);
		n = $urandom_range(0, 4);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_rand_load();
			end else if (data_style) begin
				send_blockette(($urandom_range(0, 2) == 0) ? BT_2000 : BT_1000);
			end else begin
				send_blockette(pick_type());
			end
		end
		send_end($urandom_range(0, 7) != 0, 1'($urandom), 1'($urandom), rand_text(5));
	endtask

	// Flags are still at reset: nothing may be kept
	task automatic test_reset_state();
		send_blockette(BT_1000);
		send_end(1'b1, 1'b0, 1'b0, "00BHZ");
	endtask

	// Each class, the drop rules, empty lists and ignored items
	task automatic test_directed_records();
		in_item_t it;
		write_save_flags(6'h3F);
		send_load(LIST_DATA, 4'd0, "??BHZ");
		send_load(LIST_DATA, 4'd1, "10lh?");
		send_load(LIST_NONE, 4'd15, "?????");
		it = base_item();
		transfer_item(it);
		send_blockette(BT_1000);
		send_end(1'b1, 1'b0, 1'b0, "00BHZ");
		send_blockette(BT_1000);
		send_end(1'b1, 1'b0, 1'b0, "10LHN");
		send_blockette(BT_1000);
		send_end(1'b1, 1'b0, 1'b0, "00xyz");
		// detection, later types ignored, empty list
		send_blockette(BT_DET_LO);
		send_blockette(BT_CAL_LO);
		send_end(1'b1, 1'b0, 1'b0, "?????");
		send_blockette(BT_CAL_HI);
		send_end(1'b1, 1'b0, 1'b0, "?????");
		send_blockette(BT_TIM_HI - 16'd1);
		send_blockette(BT_1000);
		send_end(1'b1, 1'b0, 1'b0, rand40());
		send_end(1'b1, 1'b1, 1'b0, rand40());
		send_blockette(BT_2000);
		send_end(1'b1, 1'b1, 1'b1, rand40());
		send_blockette(BT_1000);
		send_end(1'b1, 1'b1, 1'b1, "00BHZ");
		// header failure still reports the class
		send_blockette(16'hFFFF);
		send_blockette(16'h0000);
		send_blockette(BT_1000);
		send_end(1'b0, 1'b0, 1'b0, "00BHZ");
		send_load(LIST_DETECT, 4'd0, "?????");
		send_blockette(BT_CAL_LO - 16'd1);
		send_end(1'b1, 1'b0, 1'b0, rand40());
		// calibration list loaded in the middle of a record
		send_blockette(BT_CAL_HI);
		send_load(LIST_CALIB, 4'd0, "00?hz");
		send_end(1'b1, 1'b0, 1'b0, "00BHZ");
	endtask

	// Random records in phases, each with its own save flags
	task automatic test_random_traffic();
		logic [5:0] phase_flags [6];
		int         goal;
		phase_flags = '{6'h3F, 6'h00, 6'h15, 6'h2A, 6'h00, 6'h3F};
		phase_flags[4] = 6'($urandom);
		foreach (phase_flags[p]) begin
			write_save_flags(phase_flags[p]);
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 3)) send_rand_load();
				end else if ($urandom_range(0, 14) == 0) begin
					transfer_item(base_item());
				end else begin
					random_record();
				end
			end
		end
	endtask

	// Result check against the oldest predicted verdict
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected result: keep %0b, record_class %0d",
					result.keep, result.record_class);
				bad_checks++;
			end else begin
				want = verdicts_due.pop_front();
				if (result.keep !== want.keep) begin
					$error("keep: expected %0b, actual %0b", want.keep, result.keep);
					bad_checks++;
				end
				if (result.record_class !== want.record_class) begin
					$error("record_class: expected %0d, actual %0d",
						want.record_class, result.record_class);
					bad_checks++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_directed_records();
		test_random_traffic();
		@(negedge clk);
		start <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_checks == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[seismic_record_class_filter_core.f]
+incdir+rtl/core
rtl/core/srcf_pkg.sv
rtl/core/srcf_ctrl.sv
rtl/core/srcf_dp.sv
rtl/core/seismic_record_class_filter_core.sv
rtl/core/srcf_checker.sv
tb/tb_top.sv
